>>> rtl/pts_pkg.sv
// shared types and constants of the propensity tree sampler
// no dependencies; imported by pts_alu and propensity_tree_sampler
package pts_pkg;

  localparam int unsigned NUM_ENTRIES = 1024;
  localparam int unsigned FANOUT      = 32;

  localparam int unsigned IDX_W   = 10;
  localparam int unsigned GRP_W   = 5;
  localparam int unsigned KID_W   = 5;
  localparam int unsigned RATE_W  = 32;
  localparam int unsigned RAND_W  = 32;
  localparam int unsigned GSUM_W  = 37;
  localparam int unsigned TOT_W   = 42;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned CNT_W   = 10;

  localparam int unsigned IN_DATA_W  = 176;
  localparam int unsigned OUT_DATA_W = 56;

  localparam logic OP_SET = 1'b0;
  localparam logic OP_SEL = 1'b1;

  localparam logic LVL_LEAF  = 1'b0;
  localparam logic LVL_GROUP = 1'b1;

  typedef struct packed {
    logic acc_clr;
    logic acc_en;
    logic mul_lo;
    logic mul_hi;
  } alu_ctrl_t;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MLO   = 7'b0000100,
    S_MHI   = 7'b0001000,
    S_SUM   = 7'b0010000,
    S_SCAN  = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

endpackage

>>> rtl/pts_alu.sv
// shared arithmetic unit: selector multiply in two halves, running sum and compare
// depends on pts_pkg
module pts_alu import pts_pkg::*; (
  input  logic                clk_i,
  input  alu_ctrl_t           ctrl_i,
  input  logic [RAND_W-1:0]   rand_i,
  input  logic [TOT_W-1:0]    parent_i,
  input  logic [GSUM_W-1:0]   cur_i,
  output logic [TOT_W-1:0]    sum_o,
  output logic [TOT_W-1:0]    sel_o,
  output logic                hit_o
);

  logic [PROD_W-1:0] prod_q;
  logic [TOT_W-1:0]  sel_q;
  logic [TOT_W-1:0]  acc_q;
  logic [RAND_W-1:0] mul_b;
  logic [PROD_W-1:0] prod;

  // one multiplier, low half of the parent first, then the high bits
  assign mul_b = ctrl_i.mul_hi ? {{(RAND_W-(TOT_W-32)){1'b0}}, parent_i[TOT_W-1:32]}
                               : parent_i[31:0];
  assign prod  = {{RAND_W{1'b0}}, rand_i} * {{RAND_W{1'b0}}, mul_b};

  assign sum_o = acc_q + {{(TOT_W-GSUM_W){1'b0}}, cur_i};
  assign sel_o = sel_q;
  assign hit_o = sel_q < sum_o;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_lo) begin
      prod_q <= prod;
    end
    if (ctrl_i.mul_hi) begin
      sel_q <= {{(TOT_W-32){1'b0}}, prod_q[PROD_W-1:32]} + prod[TOT_W-1:0];
    end
    if (ctrl_i.acc_clr) begin
      acc_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_q <= sum_o;
    end
  end

endmodule

>>> rtl/propensity_tree_sampler.sv
// propensity tree sampler top level: sequencer, leaf and group memories, result register
// depends on pts_pkg and pts_alu
//
// A two-level 32-ary sum tree over 1024 leaf rates. A set request writes one leaf,
// re-sums its group of 32 leaves and then re-sums the 32 group sums into the total.
// A select request draws a selector from the total with rand_1, scans the group sums,
// then draws from the chosen group sum with rand_0 and scans its leaves; each scan
// stops where the hit falls, as the one-read-per-cycle memory port is walked by a
// single shared adder and compare. A select on a zero total skips both scans and
// reports nothing_to_select. rand_2 and rand_3 are not used at this size. After reset
// a clearing pass zeroes both memories; s_axis_tready_o stays low until it ends.
// One request is in work at a time, and the next is taken while a result waits
// on the output.
module propensity_tree_sampler import pts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // entry_index, rate_value, rand_0, rand_1, rand_2, rand_3, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // selected_index, total_rate, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,
  // nothing_to_select
  output logic                  m_axis_tuser_o
);

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               rd_vld_q;
  logic [KID_W-1:0]   rd_k_q;
  logic [GRP_W-1:0]   base_q, base_d;
  logic               lvl_q, lvl_d;
  logic [RAND_W-1:0]  rand0_q, rand1_q;
  logic [TOT_W-1:0]   parent_q, parent_d;
  logic [TOT_W-1:0]   total_q, total_d;
  logic [IDX_W-1:0]   res_sel_q, res_sel_d;
  logic               res_none_q, res_none_d;
  logic               out_vld_q;
  logic [IDX_W-1:0]   out_sel_q;
  logic [TOT_W-1:0]   out_tot_q;
  logic               out_none_q;

  logic [RATE_W-1:0]  leaf_mem [NUM_ENTRIES];
  logic [GSUM_W-1:0]  grp_mem  [FANOUT];
  logic [RATE_W-1:0]  leaf_rd_q;
  logic [GSUM_W-1:0]  grp_rd_q;

  logic               accept;
  logic               issue;
  logic               rd_last;
  logic               leaf_we;
  logic [IDX_W-1:0]   leaf_waddr;
  logic [RATE_W-1:0]  leaf_wdata;
  logic               grp_we;
  logic [GRP_W-1:0]   grp_waddr;
  logic [GSUM_W-1:0]  grp_wdata;
  logic               out_load;

  alu_ctrl_t          alu_ctrl;
  logic [GSUM_W-1:0]  cur;
  logic [TOT_W-1:0]   alu_sum;
  logic [TOT_W-1:0]   alu_sel;
  logic               alu_hit;
  logic [RAND_W-1:0]  rand_cur;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign issue           = ((state_q == S_SUM) || (state_q == S_SCAN)) && (cnt_q[CNT_W-1:KID_W] == '0);
  assign rd_last         = (rd_k_q == {KID_W{1'b1}});
  assign cur             = (lvl_q == LVL_GROUP) ? grp_rd_q
                                                : {{(GSUM_W-RATE_W){1'b0}}, leaf_rd_q};
  assign rand_cur        = (lvl_q == LVL_GROUP) ? rand1_q : rand0_q;

  pts_alu u_alu (
    .clk_i    (clk_i),
    .ctrl_i   (alu_ctrl),
    .rand_i   (rand_cur),
    .parent_i (parent_q),
    .cur_i    (cur),
    .sum_o    (alu_sum),
    .sel_o    (alu_sel),
    .hit_o    (alu_hit)
  );

  // leaf memory: cleared after reset, written by set requests
  assign leaf_we    = (state_q == S_CLEAR) || (accept && (s_axis_tuser_i == OP_SET));
  assign leaf_waddr = (state_q == S_CLEAR) ? cnt_q : s_axis_tdata_i[IDX_W-1:0];
  assign leaf_wdata = (state_q == S_CLEAR) ? '0 : s_axis_tdata_i[IDX_W+RATE_W-1:IDX_W];

  always_ff @(posedge clk_i) begin
    if (leaf_we) begin
      leaf_mem[leaf_waddr] <= leaf_wdata;
    end
    leaf_rd_q <= leaf_mem[{base_q, cnt_q[KID_W-1:0]}];
  end

  // group sum memory
  assign grp_we    = (state_q == S_CLEAR) ||
                     ((state_q == S_SUM) && rd_vld_q && rd_last && (lvl_q == LVL_LEAF));
  assign grp_waddr = (state_q == S_CLEAR) ? cnt_q[GRP_W-1:0] : base_q;
  assign grp_wdata = (state_q == S_CLEAR) ? '0 : alu_sum[GSUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (grp_we) begin
      grp_mem[grp_waddr] <= grp_wdata;
    end
    grp_rd_q <= grp_mem[cnt_q[GRP_W-1:0]];
  end

  assign out_load = (state_q == S_FIN) && (!out_vld_q || m_axis_tready_i);

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    base_d     = base_q;
    lvl_d      = lvl_q;
    parent_d   = parent_q;
    total_d    = total_q;
    res_sel_d  = res_sel_q;
    res_none_d = res_none_q;
    alu_ctrl   = '0;
    if (issue) begin
      cnt_d = cnt_q + CNT_W'(1);
    end
    unique case (state_q)
      S_CLEAR: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == {CNT_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_sel_d  = '0;
          res_none_d = 1'b0;
          cnt_d      = '0;
          if (s_axis_tuser_i == OP_SET) begin
            base_d           = s_axis_tdata_i[IDX_W-1:KID_W];
            lvl_d            = LVL_LEAF;
            alu_ctrl.acc_clr = 1'b1;
            state_d          = S_SUM;
          end else if (total_q == '0) begin
            res_none_d = 1'b1;
            state_d    = S_FIN;
          end else begin
            parent_d = total_q;
            lvl_d    = LVL_GROUP;
            state_d  = S_MLO;
          end
        end
      end
      S_MLO: begin
        alu_ctrl.mul_lo = 1'b1;
        state_d         = S_MHI;
      end
      S_MHI: begin
        alu_ctrl.mul_hi  = 1'b1;
        alu_ctrl.acc_clr = 1'b1;
        cnt_d            = '0;
        state_d          = S_SCAN;
      end
      S_SUM: begin
        if (rd_vld_q) begin
          alu_ctrl.acc_en = 1'b1;
          if (rd_last) begin
            if (lvl_q == LVL_LEAF) begin
              alu_ctrl.acc_clr = 1'b1;
              lvl_d            = LVL_GROUP;
              cnt_d            = '0;
            end else begin
              total_d = alu_sum;
              state_d = S_FIN;
            end
          end
        end
      end
      S_SCAN: begin
        if (rd_vld_q) begin
          // a scan that runs out of children takes the last one
          if (alu_hit || rd_last) begin
            if (lvl_q == LVL_GROUP) begin
              base_d   = rd_k_q;
              parent_d = {{(TOT_W-GSUM_W){1'b0}}, cur};
              lvl_d    = LVL_LEAF;
              state_d  = S_MLO;
            end else begin
              res_sel_d = {base_q, rd_k_q};
              state_d   = S_FIN;
            end
          end else begin
            alu_ctrl.acc_en = 1'b1;
          end
        end
      end
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      rd_vld_q  <= 1'b0;
      total_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= issue;
      total_q  <= total_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_k_q     <= cnt_q[KID_W-1:0];
    base_q     <= base_d;
    lvl_q      <= lvl_d;
    parent_q   <= parent_d;
    res_sel_q  <= res_sel_d;
    res_none_q <= res_none_d;
    if (accept) begin
      rand0_q <= s_axis_tdata_i[IDX_W+RATE_W+RAND_W-1:IDX_W+RATE_W];
      rand1_q <= s_axis_tdata_i[IDX_W+RATE_W+2*RAND_W-1:IDX_W+RATE_W+RAND_W];
    end
    if (out_load) begin
      out_sel_q  <= res_sel_q;
      out_none_q <= res_none_q;
      out_tot_q  <= total_q;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-IDX_W-TOT_W){1'b0}}, out_tot_q, out_sel_q};
  assign m_axis_tuser_o  = out_none_q;

  // an empty tree never names a leaf
  a_none_zero_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o[IDX_W-1:0] == '0))
    else $error("nothing_to_select with nonzero index");

  // total only moves at the end of a group re-sum
  a_total_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SUM) |=> $stable(total_q))
    else $error("total changed outside re-sum");

  // scaled selector stays below its parent sum
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (alu_sel < parent_q))
    else $error("selector not below parent sum");

  // no memory read is issued past the last child
  a_issue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN || state_q == S_SUM) |-> (cnt_q <= CNT_W'(FANOUT)))
    else $error("child counter overran");

endmodule
